### hw/rtl/dss_pkg.sv
package dss_pkg;

  typedef enum logic [1:0] {
    OP_PUSH_LOW  = 2'd0,
    OP_POP_LOW   = 2'd1,
    OP_PUSH_HIGH = 2'd2,
    OP_POP_HIGH  = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  localparam int unsigned PortDataWidth = 32;
  localparam int unsigned OccWidth      = 4;

  // controller -> datapath
  typedef struct packed {
    logic exec;  // execute the request on the input ports this cycle
  } cmd_t;

endpackage

### hw/rtl/dss_ctrl.sv
module dss_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output dss_pkg::cmd_t cmd_o
);
  import dss_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_RESP
  } state_e;

  state_e state_q;
  logic   in_ready_q;
  logic   out_valid_q;

  assign cmd_o.exec  = in_valid_i & in_ready_q;
  assign in_ready_o  = in_ready_q;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      in_ready_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i && in_ready_q) begin
            state_q     <= S_RESP;
            in_ready_q  <= 1'b0;
            out_valid_q <= 1'b1;
          end else begin
            in_ready_q <= 1'b1;
          end
        end
        S_RESP: begin
          if (out_ready_i) begin
            state_q     <= S_IDLE;
            in_ready_q  <= 1'b1;
            out_valid_q <= 1'b0;
          end
        end
        default: begin
          state_q     <= S_IDLE;
          in_ready_q  <= 1'b0;
          out_valid_q <= 1'b0;
        end
      endcase
    end
  end

endmodule

### hw/rtl/dss_datapath.sv
module dss_datapath #(
  parameter int unsigned DEPTH      = 8,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  dss_pkg::cmd_t                       cmd_i,
  input  logic [1:0]                          opcode_i,
  input  logic [dss_pkg::PortDataWidth-1:0]   push_value_i,
  output logic [dss_pkg::PortDataWidth-1:0]   pop_value_o,
  output logic [1:0]                          status_o,
  output logic [dss_pkg::OccWidth-1:0]        low_occupancy_o,
  output logic [dss_pkg::OccWidth-1:0]        high_occupancy_o
);
  import dss_pkg::*;

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned OW = CW + OccWidth;
  localparam int unsigned XW = (DATA_WIDTH > PortDataWidth) ? DATA_WIDTH : PortDataWidth;

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  logic [CW-1:0]         low_q, low_d;
  logic [CW-1:0]         high_q, high_d;
  logic [DATA_WIDTH-1:0] rd_data_q;
  logic                  pop_ok_q, pop_ok_d;
  status_e               status_q, status_d;

  opcode_e               op;
  logic                  full;
  logic                  wr_en;
  logic [AW-1:0]         addr;
  logic [CW-1:0]         addr_wide;
  logic [XW-1:0]         push_ext;
  logic [XW-1:0]         pop_ext;
  logic [OW-1:0]         low_ext;
  logic [OW-1:0]         high_ext;

  assign op   = opcode_e'(opcode_i);
  assign full = ({1'b0, low_q} + {1'b0, high_q}) >= (CW + 1)'(DEPTH);

  always_comb begin
    low_d     = low_q;
    high_d    = high_q;
    status_d  = ST_OK;
    pop_ok_d  = 1'b0;
    wr_en     = 1'b0;
    addr_wide = low_q;
    case (op)
      OP_PUSH_LOW: begin
        addr_wide = low_q;
        if (full) begin
          status_d = ST_FULL;
        end else begin
          wr_en = 1'b1;
          low_d = low_q + CW'(1);
        end
      end
      OP_POP_LOW: begin
        addr_wide = low_q - CW'(1);
        if (low_q == '0) begin
          status_d = ST_EMPTY;
        end else begin
          pop_ok_d = 1'b1;
          low_d    = low_q - CW'(1);
        end
      end
      OP_PUSH_HIGH: begin
        addr_wide = CW'(DEPTH - 1) - high_q;
        if (full) begin
          status_d = ST_FULL;
        end else begin
          wr_en  = 1'b1;
          high_d = high_q + CW'(1);
        end
      end
      OP_POP_HIGH: begin
        addr_wide = CW'(DEPTH) - high_q;
        if (high_q == '0) begin
          status_d = ST_EMPTY;
        end else begin
          pop_ok_d = 1'b1;
          high_d   = high_q - CW'(1);
        end
      end
      default: begin
        status_d = ST_OK;
      end
    endcase
  end

  assign addr     = addr_wide[AW-1:0];
  assign push_ext = XW'(push_value_i);

  // single-port store, read data registered
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      if (wr_en) begin
        mem[addr] <= push_ext[DATA_WIDTH-1:0];
      end
      rd_data_q <= mem[addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q    <= '0;
      high_q   <= '0;
      pop_ok_q <= 1'b0;
      status_q <= ST_OK;
    end else if (cmd_i.exec) begin
      low_q    <= low_d;
      high_q   <= high_d;
      pop_ok_q <= pop_ok_d;
      status_q <= status_d;
    end
  end

  assign pop_ext  = XW'(rd_data_q);
  assign low_ext  = OW'(low_q);
  assign high_ext = OW'(high_q);

  assign pop_value_o      = pop_ok_q ? pop_ext[PortDataWidth-1:0] : '0;
  assign status_o         = status_q;
  assign low_occupancy_o  = low_ext[OccWidth-1:0];
  assign high_occupancy_o = high_ext[OccWidth-1:0];

endmodule

### hw/rtl/dual_stack_shared_store_core.sv
// Two LIFO stacks in one shared store: low stack grows up from entry 0, high down from DEPTH-1.
// Latency: a result is valid the cycle after its request transaction is accepted.
// Flow: the FSM holds one request at a time, and the result register must be taken
//   before the next request is accepted.
// Reset (rst_ni, async, active low): both stack counts cleared, no result pending;
//   in_ready_o is registered and rises after reset release. Store contents are not cleared.
module dual_stack_shared_store_core #(
  parameter int unsigned DEPTH      = 8,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // request channel
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [1:0]                        opcode_i,
  input  logic [dss_pkg::PortDataWidth-1:0] push_value_i,
  // result channel
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [dss_pkg::PortDataWidth-1:0] pop_value_o,
  output logic [1:0]                        status_o,
  output logic [dss_pkg::OccWidth-1:0]      low_occupancy_o,
  output logic [dss_pkg::OccWidth-1:0]      high_occupancy_o
);
  import dss_pkg::*;

  cmd_t cmd;

  // Controller: accepts a request, then holds the result until it is taken.
  dss_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  // Datapath: full/empty checks, counts, store access and result registers.
  // The result fields are registers updated only on an accepted request, so
  // they stay stable while out_valid_o waits for out_ready_i.
  dss_datapath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .opcode_i         (opcode_i),
    .push_value_i     (push_value_i),
    .pop_value_o      (pop_value_o),
    .status_o         (status_o),
    .low_occupancy_o  (low_occupancy_o),
    .high_occupancy_o (high_occupancy_o)
  );

endmodule
